@@ hw/rtl/rtsk_pkg.sv @@
// Package for the rank-to-sparse-key mapper: hash constants, op codes,
// register indexes and the side-band type carried down the pipeline.
// No dependencies.
package rtsk_pkg;

  // Field widths
  localparam int unsigned KC_W           = 41;
  localparam int unsigned RANK_W         = 40;
  localparam int unsigned EPOCH_W        = 32;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned INDEX_BITS_DEF = 40;
  localparam int unsigned CFG_IDX_W      = 2;

  // Hash constants
  localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B     = 64'h94D049BB133111EB;
  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  localparam logic [19:0] EPOCH_MUL = 20'd1000003;

  // Op codes; the fourth code behaves as scrambled
  typedef enum logic [1:0] {
    OP_SCRAMBLED = 2'd0,
    OP_CLUSTERED = 2'd1,
    OP_DRIFT     = 2'd2
  } op_e;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_SEED  = 2'd2;

  // Clustered-mode result travels beside the hash path
  typedef struct packed {
    logic            cl;
    logic [KC_W-1:0] cl_idx;
  } side_t;

endpackage

@@ hw/rtl/rtsk_if.sv @@
// Valid/ready channel interfaces of the rank-to-sparse-key mapper.
// Depends on rtsk_pkg.
interface rtsk_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [rtsk_pkg::RANK_W-1:0]  rank;
  logic [rtsk_pkg::EPOCH_W-1:0] epoch;

  modport source (output valid, output op, output rank, output epoch, input ready);
  modport sink   (input valid, input op, input rank, input epoch, output ready);
endinterface

interface rtsk_out_if #(
  parameter int unsigned INDEX_BITS = rtsk_pkg::INDEX_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [rtsk_pkg::KEY_W-1:0] key;
  logic [INDEX_BITS-1:0]      index;

  modport source (output valid, output key, output index, input ready);
  modport sink   (input valid, input key, input index, output ready);
endinterface

@@ hw/rtl/rank_to_sparse_key_mapper_top.sv @@
// Rank-to-sparse-key mapper, top level and full datapath pipeline.
// Depends on rtsk_pkg and the channel interfaces in rtsk_if.sv.
//
// Usage:
//   in_i carries one beat per request: op (scrambled, clustered, drift),
//   a popularity rank and a drift epoch. out_o returns one beat per request
//   with the 64-bit sparse key and the chosen insertion index, in order.
//   The key count, key seed and base scramble seed registers are written
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so only
//   while no beat is in flight, as the block does not enforce it.
// Throughput and stages: one beat per cycle while out_o is not stalled;
//   4 seed/scramble stages, 8 FNV stages (one byte each), 32 modulo
//   stages (two remainder bits each, restoring), and 5 finalizer stages
//   with split 32-bit partial products.
// Stall:
//   the whole pipeline advances when the output register is empty or
//   being taken; while the receiver holds off, every stage holds and
//   in_i.ready is low. No beat is lost or repeated.
// Reset:
//   rst_ni clears all valid bits and sets key_count to 1, seeds to 0.
module rank_to_sparse_key_mapper_top #(
  parameter int unsigned INDEX_BITS = rtsk_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rtsk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                    cfg_wdata_i,
  rtsk_in_if.sink                        in_i,
  rtsk_out_if.source                     out_o
);
  import rtsk_pkg::*;

  localparam int unsigned FNV_N  = 8;
  localparam int unsigned DIV_K  = 2;
  localparam int unsigned DIV_N  = 64 / DIV_K;
  localparam int unsigned SIDE_N = 4 + FNV_N + DIV_N;
  localparam int unsigned NS     = SIDE_N + 5;
  localparam logic [KC_W:0] CAP  = (KC_W+1)'(1) << ((INDEX_BITS < KC_W) ? INDEX_BITS : KC_W);

  // FNV-1a step, prime = 2^40 + 0x1B3 as shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] t;
    t = h ^ {56'd0, b};
    return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
  endfunction

  // Configuration registers
  logic [KC_W-1:0] kc_q;
  logic [63:0]     kseed_q, bseed_q;
  logic [KC_W-1:0] eff_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kc_q    <= KC_W'(1);
      kseed_q <= '0;
      bseed_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_COUNT: kc_q    <= cfg_wdata_i[KC_W-1:0];
        REG_KEY_SEED:  kseed_q <= cfg_wdata_i;
        REG_RUN_SEED:  bseed_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective modulus: at least 1, at most 2^INDEX_BITS
  always_comb begin
    eff_n = (kc_q == '0) ? KC_W'(1) : kc_q;
    if ({1'b0, eff_n} > CAP) eff_n = CAP[KC_W-1:0];
  end

  // Pipeline control
  logic          en;
  logic [NS-1:0] vld_q;

  assign en         = !vld_q[NS-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  // Stage 1: epoch product, clustered index
  logic [51:0]       ep_prod_q;
  logic              drift_q;
  logic [RANK_W-1:0] rank1_q;
  side_t             side_d;
  side_t             side_q [SIDE_N];

  always_comb begin
    side_d.cl     = (in_i.op == OP_CLUSTERED);
    side_d.cl_idx = ({1'b0, in_i.rank} >= eff_n) ? eff_n - KC_W'(1) : {1'b0, in_i.rank};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ep_prod_q <= in_i.epoch * EPOCH_MUL;
      drift_q   <= (in_i.op == OP_DRIFT);
      rank1_q   <= in_i.rank;
      side_q[0] <= side_d;
    end
  end

  // Side band follows the hash path
  for (genvar k = 1; k < SIDE_N; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) side_q[k] <= side_q[k-1];
    end
  end

  // Stage 2: seed
  logic [63:0]       seed_q;
  logic [RANK_W-1:0] rank2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      seed_q  <= bseed_q + (drift_q ? {12'd0, ep_prod_q} : 64'd0);
      rank2_q <= rank1_q;
    end
  end

  // Stage 3: partial products of seed * GOLDEN
  logic [63:0]       sp1, sp2;
  logic [63:0]       pp0_q;
  logic [31:0]       pp1_q, pp2_q;
  logic [RANK_W-1:0] rank3_q;

  assign sp1 = seed_q[63:32] * GOLDEN[31:0];
  assign sp2 = seed_q[31:0] * GOLDEN[63:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp0_q   <= seed_q[31:0] * GOLDEN[31:0];
      pp1_q   <= sp1[31:0];
      pp2_q   <= sp2[31:0];
      rank3_q <= rank2_q;
    end
  end

  // Stage 4: scrambled rank
  logic [63:0] x_q;

  always_ff @(posedge clk_i) begin
    if (en) x_q <= {24'd0, rank3_q} ^ (pp0_q + {pp1_q + pp2_q, 32'd0});
  end

  // FNV-1a steps from a non-standard basis, one byte per stage
  logic [63:0] fh_q [FNV_N];
  logic [63:0] fx_q [FNV_N-1];

  for (genvar j = 0; j < FNV_N; j++) begin : g_fnv
    logic [63:0] h_in, x_in;
    if (j == 0) begin : g_first
      assign h_in = FNV_BASIS;
      assign x_in = x_q;
    end else begin : g_next
      assign h_in = fh_q[j-1];
      assign x_in = fx_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) fh_q[j] <= fnv_step(h_in, x_in[7:0]);
    end
    if (j < FNV_N - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en) fx_q[j] <= x_in >> 8;
      end
    end
  end

  // Modulo: restoring, DIV_K remainder bits per stage
  logic [KC_W-1:0] drem_q [DIV_N];
  logic [63:0]     ddvd_q [DIV_N-1];

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic [KC_W-1:0] rem_in, rem_d;
    logic [63:0]     dvd_in, dvd_d;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = fh_q[FNV_N-1];
    end else begin : g_next
      assign rem_in = drem_q[k-1];
      assign dvd_in = ddvd_q[k-1];
    end
    always_comb begin
      logic [KC_W:0] r;
      rem_d = rem_in;
      dvd_d = dvd_in;
      for (int s = 0; s < DIV_K; s++) begin
        r     = {rem_d, dvd_d[63]};
        dvd_d = dvd_d << 1;
        if (r >= {1'b0, eff_n}) r = r - {1'b0, eff_n};
        rem_d = r[KC_W-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) drem_q[k] <= rem_d;
    end
    if (k < DIV_N - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en) ddvd_q[k] <= dvd_d;
      end
    end
  end

  // Finalizer stage 1: index select, add and first xor-shift
  logic [KC_W-1:0] fidx_sel, fidx1_q, fidx2_q, fidx3_q, fidx4_q;
  logic [63:0]     fv, fu_q;

  assign fidx_sel = side_q[SIDE_N-1].cl ? side_q[SIDE_N-1].cl_idx : drem_q[DIV_N-1];
  assign fv       = ({23'd0, fidx_sel} ^ kseed_q) + GOLDEN;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fu_q    <= fv ^ (fv >> 30);
      fidx1_q <= fidx_sel;
    end
  end

  // Finalizer stage 2: partial products of u * MIX_A
  logic [63:0] am1, am2, a0_q, ft_sum;
  logic [31:0] a1_q, a2_q;

  assign am1 = fu_q[63:32] * MIX_A[31:0];
  assign am2 = fu_q[31:0] * MIX_A[63:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q    <= fu_q[31:0] * MIX_A[31:0];
      a1_q    <= am1[31:0];
      a2_q    <= am2[31:0];
      fidx2_q <= fidx1_q;
    end
  end

  // Finalizer stage 3: sum and second xor-shift
  logic [63:0] ft_q;

  assign ft_sum = a0_q + {a1_q + a2_q, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      ft_q    <= ft_sum ^ (ft_sum >> 27);
      fidx3_q <= fidx2_q;
    end
  end

  // Finalizer stage 4: partial products of t * MIX_B
  logic [63:0] bm1, bm2, b0_q, fy_sum;
  logic [31:0] b1_q, b2_q;

  assign bm1 = ft_q[63:32] * MIX_B[31:0];
  assign bm2 = ft_q[31:0] * MIX_B[63:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q    <= ft_q[31:0] * MIX_B[31:0];
      b1_q    <= bm1[31:0];
      b2_q    <= bm2[31:0];
      fidx4_q <= fidx3_q;
    end
  end

  // Finalizer stage 5: output register
  logic [KEY_W-1:0]      out_key_q;
  logic [INDEX_BITS-1:0] out_index_q;

  assign fy_sum = b0_q + {b1_q + b2_q, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_key_q   <= fy_sum ^ (fy_sum >> 31);
      out_index_q <= INDEX_BITS'(fidx4_q);
    end
  end

  assign out_o.valid = vld_q[NS-1];
  assign out_o.key   = out_key_q;
  assign out_o.index = out_index_q;

  // Assertions
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[0] == $past(in_i.valid))
    else $error("first stage valid does not follow an accepted beat");

  a_cl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && side_q[0].cl |-> side_q[0].cl_idx <= {1'b0, rank1_q})
    else $error("clustered index exceeds rank");

endmodule
